// File: hw/rtl/colq_pkg.sv
package colq_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_HIT   = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOTAG = 2'd3
    } status_t;

    localparam int TAG_W  = 16;
    localparam int POS_W  = 16;
    localparam int SIZE_W = 15;

    // stored or listener collider, raw fields as they arrive
    typedef struct packed {
        logic              kind;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] rad;
    } shape_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        shape_t           shape;
    } entry_t;

    typedef struct packed {
        status_t          status;
        logic [TAG_W-1:0] tag;
        logic             kind;
        logic             last;
    } res_t;

    // result queue
    localparam int RES_DEPTH = 8;
    localparam int RES_AW    = 3;
    localparam int RES_CW    = RES_AW + 1;
    // entries in flight between read issue and hit: memory, two overlap stages,
    // the pending hit register and the closing result need room in the queue
    localparam int RES_ISSUE_MAX = RES_DEPTH - 5;

endpackage

// File: hw/rtl/collider_overlap_query_engine_core.sv
// insert and remove: one table read per entry; the result follows once the walk has drained
// query: one table read per cycle over all TABLE_DEPTH entries, then the closing result;
//   the walk pauses while the result queue holds more than 3 results
// the unused command skips the walk and gives its result from the finish state
// a new item is taken the cycle after the closing result enters the result queue
// reset clears all valid bits; the table contents need no clearing
module collider_overlap_query_engine_core #(
    parameter int TABLE_DEPTH = 32,
    parameter int COORD_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [15:0] s_collider_tag,
    input  logic        s_shape_kind,
    input  logic [15:0] s_pos_x,
    input  logic [15:0] s_pos_y,
    input  logic [14:0] s_size_x,
    input  logic [14:0] s_size_y,
    input  logic [14:0] s_radius,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_hit_tag,
    output logic        m_hit_kind,
    output logic        m_last
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WALK   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    colq_pkg::cmd_t                 cmd_reg;
    logic [colq_pkg::TAG_W-1:0]     tag_reg;
    colq_pkg::shape_t               shape_reg;
    logic [CNTW-1:0]                cnt_reg, cnt_next;
    logic                           found_reg, found_next, free_reg, free_next;
    logic [AW-1:0]                  found_idx_reg, found_idx_next;
    logic [AW-1:0]                  free_idx_reg, free_idx_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [colq_pkg::TAG_W-1:0]     pend_tag_reg, pend_tag_next;
    logic                           pend_kind_reg, pend_kind_next;

    logic                           accept;
    logic                           rd_en, rd_ack, rd_vld;
    logic [AW-1:0]                  rd_idx;
    colq_pkg::entry_t               rd_data;
    logic                           wr_en, clr_en;
    logic [AW-1:0]                  wr_addr;
    colq_pkg::entry_t               wr_data;
    logic                           ov_in, ov_hit, ov_kind, ov_busy;
    logic [colq_pkg::TAG_W-1:0]     ov_tag;
    logic                           push;
    colq_pkg::res_t                 push_data, head;
    logic [colq_pkg::RES_CW-1:0]    res_count;
    logic                           is_query;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_query = (cmd_reg == colq_pkg::CMD_QUERY);
    assign ov_in    = rd_ack && rd_vld && is_query;
    assign wr_data  = '{tag: tag_reg, shape: shape_reg};

    colq_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_ack  (rd_ack),
        .rd_vld  (rd_vld),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .clr_en  (clr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    colq_overlap #(
        .COORD_BITS (COORD_BITS)
    ) u_overlap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ov_in),
        .entry     (rd_data),
        .listener  (shape_reg),
        .hit_valid (ov_hit),
        .hit_tag   (ov_tag),
        .hit_kind  (ov_kind),
        .busy      (ov_busy)
    );

    colq_res_fifo u_res (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (m_valid && m_ready),
        .out_valid (m_valid),
        .out_data  (head),
        .count     (res_count)
    );

    assign m_status   = head.status;
    assign m_hit_tag  = head.tag;
    assign m_hit_kind = head.kind;
    assign m_last     = head.last;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        pend_kind_next  = pend_kind_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        clr_en          = 1'b0;
        wr_addr         = found_idx_reg;
        push            = 1'b0;
        push_data       = '{status: colq_pkg::ST_DONE, tag: '0, kind: 1'b0, last: 1'b1};

        // tag lookup and first free slot while walking for insert or remove
        if (rd_ack && !is_query) begin
            if (rd_vld && rd_data.tag == tag_reg && !found_reg) begin
                found_next     = 1'b1;
                found_idx_next = rd_idx;
            end
            if (!rd_vld && !free_reg) begin
                free_next     = 1'b1;
                free_idx_next = rd_idx;
            end
        end

        // hold one hit back so the final one can carry last
        if (ov_hit) begin
            if (pend_valid_reg) begin
                push      = 1'b1;
                push_data = '{status: colq_pkg::ST_HIT, tag: pend_tag_reg,
                              kind: pend_kind_reg, last: 1'b0};
            end
            pend_valid_next = 1'b1;
            pend_tag_next   = ov_tag;
            pend_kind_next  = ov_kind;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cnt_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    case (colq_pkg::cmd_t'(s_command))
                        colq_pkg::CMD_INSERT,
                        colq_pkg::CMD_REMOVE,
                        colq_pkg::CMD_QUERY: state_next = S_WALK;
                        default:             state_next = S_FINISH;
                    endcase
                end
            end
            S_WALK: begin
                if (!is_query || res_count <= colq_pkg::RES_CW'(colq_pkg::RES_ISSUE_MAX)) begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(TABLE_DEPTH - 1)) begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!rd_ack && !ov_busy) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (res_count != colq_pkg::RES_CW'(colq_pkg::RES_DEPTH)) begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                    case (cmd_reg)
                        colq_pkg::CMD_INSERT: begin
                            if (found_reg) begin
                                wr_en = 1'b1;
                            end else if (free_reg) begin
                                wr_en   = 1'b1;
                                wr_addr = free_idx_reg;
                            end else begin
                                push_data.status = colq_pkg::ST_FULL;
                            end
                        end
                        colq_pkg::CMD_REMOVE: begin
                            if (found_reg) begin
                                clr_en = 1'b1;
                            end else begin
                                push_data.status = colq_pkg::ST_NOTAG;
                            end
                        end
                        colq_pkg::CMD_QUERY: begin
                            if (pend_valid_reg) begin
                                push_data = '{status: colq_pkg::ST_HIT, tag: pend_tag_reg,
                                              kind: pend_kind_reg, last: 1'b1};
                            end
                            pend_valid_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            free_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            found_reg      <= found_next;
            free_reg       <= free_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        pend_tag_reg  <= pend_tag_next;
        pend_kind_reg <= pend_kind_next;
        if (accept) begin
            cmd_reg         <= colq_pkg::cmd_t'(s_command);
            tag_reg         <= s_collider_tag;
            shape_reg.kind  <= s_shape_kind;
            shape_reg.px    <= s_pos_x;
            shape_reg.py    <= s_pos_y;
            shape_reg.sx    <= s_size_x;
            shape_reg.sy    <= s_size_y;
            shape_reg.rad   <= s_radius;
        end
    end

endmodule

// File: hw/rtl/colq_table.sv
module colq_table #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic                 rd_ack,
    output logic                 rd_vld,
    output logic [AW-1:0]        rd_idx,
    output colq_pkg::entry_t     rd_data,
    input  logic                 wr_en,
    input  logic                 clr_en,
    input  logic [AW-1:0]        wr_addr,
    input  colq_pkg::entry_t     wr_data
);

    colq_pkg::entry_t mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic             ack_reg;
    logic             vld_reg;
    logic [AW-1:0]    idx_reg;
    colq_pkg::entry_t data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_reg <= mem_reg[rd_addr];
            idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ack_reg   <= 1'b0;
            vld_reg   <= 1'b0;
        end else begin
            ack_reg <= rd_en;
            if (rd_en) begin
                vld_reg <= valid_reg[rd_addr];
            end
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end else if (clr_en) begin
                valid_reg[wr_addr] <= 1'b0;
            end
        end
    end

    assign rd_ack  = ack_reg;
    assign rd_vld  = vld_reg;
    assign rd_idx  = idx_reg;
    assign rd_data = data_reg;

endmodule

// File: hw/rtl/colq_overlap.sv
module colq_overlap #(
    parameter int COORD_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  colq_pkg::entry_t                entry,
    input  colq_pkg::shape_t                listener,
    output logic                            hit_valid,
    output logic [colq_pkg::TAG_W-1:0]      hit_tag,
    output logic                            hit_kind,
    output logic                            busy
);

    localparam int CW = (COORD_BITS < colq_pkg::POS_W) ? COORD_BITS : colq_pkg::POS_W;
    localparam int SH = colq_pkg::POS_W - CW;
    localparam int SW = 18;
    localparam int AB = 17;
    localparam int RW = colq_pkg::SIZE_W + 1;
    localparam int QW = 2 * AB + 1;

    function automatic logic signed [SW-1:0] to_coord(input logic [colq_pkg::POS_W-1:0] raw);
        logic signed [colq_pkg::POS_W-1:0] t;
        t = signed'(raw << SH);
        return SW'(t >>> SH);
    endfunction

    function automatic logic signed [SW-1:0] to_len(input logic [colq_pkg::SIZE_W-1:0] v);
        return signed'({{(SW - colq_pkg::SIZE_W){1'b0}}, v});
    endfunction

    logic signed [SW-1:0] lx, ly, lx2, ly2, ex, ey, ex2, ey2;
    logic signed [SW-1:0] rx, ry, rx2, ry2, cx, cy, nx, ny;
    logic signed [SW-1:0] dx, dy;
    logic [RW-1:0]        rad;
    logic                 both_rect, both_circ, rr_hit;

    // stage a: box test, or clamp and center difference
    always_comb begin
        lx  = to_coord(listener.px);
        ly  = to_coord(listener.py);
        ex  = to_coord(entry.shape.px);
        ey  = to_coord(entry.shape.py);
        lx2 = lx + to_len(listener.sx);
        ly2 = ly + to_len(listener.sy);
        ex2 = ex + to_len(entry.shape.sx);
        ey2 = ey + to_len(entry.shape.sy);
        both_rect = !listener.kind && !entry.shape.kind;
        both_circ = listener.kind && entry.shape.kind;
        rr_hit = !(lx2 < ex || ex2 < lx || ly2 < ey || ey2 < ly);
        if (!listener.kind) begin
            rx = lx; ry = ly; rx2 = lx2; ry2 = ly2; cx = ex; cy = ey;
        end else begin
            rx = ex; ry = ey; rx2 = ex2; ry2 = ey2; cx = lx; cy = ly;
        end
        nx = (cx < rx) ? rx : ((cx > rx2) ? rx2 : cx);
        ny = (cy < ry) ? ry : ((cy > ry2) ? ry2 : cy);
        if (both_circ) begin
            dx  = ex - lx;
            dy  = ey - ly;
            rad = RW'(listener.rad) + RW'(entry.shape.rad);
        end else begin
            dx  = cx - nx;
            dy  = cy - ny;
            rad = RW'(listener.kind ? listener.rad : entry.shape.rad);
        end
    end

    logic                        a_valid_reg, b_valid_reg;
    logic                        a_rr_reg, a_rrhit_reg, b_rr_reg, b_rrhit_reg;
    logic signed [SW-1:0]        a_dx_reg, a_dy_reg;
    logic [RW-1:0]               a_rad_reg;
    logic [colq_pkg::TAG_W-1:0]  a_tag_reg, b_tag_reg;
    logic                        a_kind_reg, b_kind_reg;
    logic [2*AB-1:0]             b_sqx_reg, b_sqy_reg;
    logic [2*RW-1:0]             b_rsq_reg;
    logic [AB-1:0]               adx, ady;

    always_comb begin
        adx = a_dx_reg[SW-1] ? AB'(-a_dx_reg) : AB'(a_dx_reg);
        ady = a_dy_reg[SW-1] ? AB'(-a_dy_reg) : AB'(a_dy_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_rr_reg    <= both_rect;
        a_rrhit_reg <= rr_hit;
        a_dx_reg    <= dx;
        a_dy_reg    <= dy;
        a_rad_reg   <= rad;
        a_tag_reg   <= entry.tag;
        a_kind_reg  <= entry.shape.kind;
        // stage b: squares
        b_rr_reg    <= a_rr_reg;
        b_rrhit_reg <= a_rrhit_reg;
        b_sqx_reg   <= adx * adx;
        b_sqy_reg   <= ady * ady;
        b_rsq_reg   <= a_rad_reg * a_rad_reg;
        b_tag_reg   <= a_tag_reg;
        b_kind_reg  <= a_kind_reg;
    end

    // stage c: squared distance against squared radius, or the box test result for two rectangles
    assign hit_valid = b_valid_reg && (b_rr_reg ? b_rrhit_reg :
                       (QW'(b_sqx_reg) + QW'(b_sqy_reg) <= QW'(b_rsq_reg)));
    assign hit_tag   = b_tag_reg;
    assign hit_kind  = b_kind_reg;
    assign busy      = a_valid_reg || b_valid_reg;

endmodule

// File: hw/rtl/colq_res_fifo.sv
module colq_res_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  colq_pkg::res_t                push_data,
    input  logic                          pop,
    output logic                          out_valid,
    output colq_pkg::res_t                out_data,
    output logic [colq_pkg::RES_CW-1:0]   count
);

    colq_pkg::res_t                 fifo_reg [colq_pkg::RES_DEPTH];
    logic [colq_pkg::RES_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [colq_pkg::RES_CW-1:0]    count_reg;
    logic                           do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = fifo_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule
